// File: rtl/braille_window_navigator_defines.svh
// Assertion helpers shared by the navigator modules
`ifndef BRAILLE_WINDOW_NAVIGATOR_DEFINES_SVH
`define BRAILLE_WINDOW_NAVIGATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, quiet during reset
`define BWN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet during reset
`define BWN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bwn_pkg.sv
package bwn_pkg;

  localparam int PaddrW = 5;
  localparam int DefMaxWindowCells = 320;

  localparam int VERT_STEP = 5;
  localparam int HALF_DIV = 2;
  localparam int EDGE_DIV = 4;

  // register reset values
  localparam logic [7:0] RstScreenCols = 8'd80;
  localparam logic [7:0] RstScreenRows = 8'd25;
  localparam logic [6:0] RstWindowCols = 7'd40;
  localparam logic [2:0] RstWindowRows = 3'd1;
  localparam logic [3:0] RstCurOn      = 4'd3;
  localparam logic [3:0] RstCurOff     = 4'd3;
  localparam logic [3:0] RstCapsOn     = 4'd4;
  localparam logic [3:0] RstCapsOff    = 4'd2;

  // mode flag bit positions
  localparam int FlagVisible  = 0;
  localparam int FlagBlink    = 1;
  localparam int FlagCapBlink = 2;
  localparam int FlagSlide    = 5;
  localparam int FlagTrack    = 7;
  localparam int FlagInfo     = 9;
  localparam logic [9:0] FlagsInit = 10'h0C3;

  typedef enum logic [2:0] {
    REG_SCREEN_COLS = 3'd0,
    REG_SCREEN_ROWS = 3'd1,
    REG_WINDOW_COLS = 3'd2,
    REG_WINDOW_ROWS = 3'd3,
    REG_CUR_ON      = 3'd4,
    REG_CUR_OFF     = 3'd5,
    REG_CAPS_ON     = 3'd6,
    REG_CAPS_OFF    = 3'd7
  } reg_idx_e;

  typedef enum logic [4:0] {
    CMD_TOP           = 5'd0,
    CMD_ORIGIN        = 5'd1,
    CMD_BOTTOM        = 5'd2,
    CMD_BOTTOM_LEFT   = 5'd3,
    CMD_WIN_UP        = 5'd4,
    CMD_WIN_DOWN      = 5'd5,
    CMD_LINE_UP       = 5'd6,
    CMD_LINE_DOWN     = 5'd7,
    CMD_GO_CURSOR     = 5'd8,
    CMD_LINE_BEGIN    = 5'd9,
    CMD_LINE_END      = 5'd10,
    CMD_CHAR_LEFT     = 5'd11,
    CMD_CHAR_RIGHT    = 5'd12,
    CMD_HALF_LEFT     = 5'd13,
    CMD_HALF_RIGHT    = 5'd14,
    CMD_FULL_LEFT     = 5'd15,
    CMD_FULL_RIGHT    = 5'd16,
    CMD_ROUTE         = 5'd17,
    CMD_TOG_VISIBLE   = 5'd18,
    CMD_TOG_BLINK     = 5'd19,
    CMD_TOG_CAPBLINK  = 5'd20,
    CMD_TOG_BIGCURSOR = 5'd21,
    CMD_TOG_SIXDOTS   = 5'd22,
    CMD_TOG_SLIDE     = 5'd23,
    CMD_TOG_SOUND     = 5'd24,
    CMD_TOG_TRACK     = 5'd25,
    CMD_TOG_ATTRIB    = 5'd26,
    CMD_TOG_INFO      = 5'd27
  } cmd_e;

  typedef enum logic [2:0] {
    CUE_NONE   = 3'd0,
    CUE_BOUNCE = 3'd1,
    CUE_WRAP_UP = 3'd2,
    CUE_WRAP_DOWN = 3'd3,
    CUE_ON     = 3'd4,
    CUE_OFF    = 3'd5,
    CUE_LINK   = 3'd6,
    CUE_UNLINK = 3'd7
  } cue_e;

  typedef struct packed {
    logic [7:0] screen_cols;
    logic [7:0] screen_rows;
    logic [6:0] window_cols;
    logic [2:0] window_rows;
    logic [3:0] cur_on;
    logic [3:0] cur_off;
    logic [3:0] caps_on;
    logic [3:0] caps_off;
  } cfg_t;

  typedef struct packed {
    logic take;
    logic exec;
    logic div_start;
    logic div_sel;
    logic place;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_place;
    logic div_busy;
    logic div_done;
    logic out_free;
  } ctrl_sts_t;

  typedef logic signed [10:0] sw_t;

  function automatic sw_t sx8(input logic [7:0] v);
    return sw_t'({3'b000, v});
  endfunction

  function automatic sw_t sx7(input logic [6:0] v);
    return sw_t'({4'b0000, v});
  endfunction

  function automatic logic [7:0] clamp_pos(input sw_t v, input logic [7:0] hi);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > sx8(hi)) begin
      r = hi;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/bwn_regs.sv
module bwn_regs import bwn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // a zero written counts as one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{RstScreenCols, RstScreenRows, RstWindowCols, RstWindowRows,
                 RstCurOn, RstCurOff, RstCapsOn, RstCapsOff};
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_SCREEN_COLS: cfg_q.screen_cols <= (pwdata[7:0] == 8'd0) ? 8'd1 : pwdata[7:0];
        REG_SCREEN_ROWS: cfg_q.screen_rows <= (pwdata[7:0] == 8'd0) ? 8'd1 : pwdata[7:0];
        REG_WINDOW_COLS: cfg_q.window_cols <= (pwdata[6:0] == 7'd0) ? 7'd1 : pwdata[6:0];
        REG_WINDOW_ROWS: cfg_q.window_rows <= (pwdata[2:0] == 3'd0) ? 3'd1 : pwdata[2:0];
        REG_CUR_ON:      cfg_q.cur_on      <= (pwdata[3:0] == 4'd0) ? 4'd1 : pwdata[3:0];
        REG_CUR_OFF:     cfg_q.cur_off     <= (pwdata[3:0] == 4'd0) ? 4'd1 : pwdata[3:0];
        REG_CAPS_ON:     cfg_q.caps_on     <= (pwdata[3:0] == 4'd0) ? 4'd1 : pwdata[3:0];
        REG_CAPS_OFF:    cfg_q.caps_off    <= (pwdata[3:0] == 4'd0) ? 4'd1 : pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SCREEN_COLS: prdata = {24'd0, cfg_q.screen_cols};
      REG_SCREEN_ROWS: prdata = {24'd0, cfg_q.screen_rows};
      REG_WINDOW_COLS: prdata = {25'd0, cfg_q.window_cols};
      REG_WINDOW_ROWS: prdata = {29'd0, cfg_q.window_rows};
      REG_CUR_ON:      prdata = {28'd0, cfg_q.cur_on};
      REG_CUR_OFF:     prdata = {28'd0, cfg_q.cur_off};
      REG_CAPS_ON:     prdata = {28'd0, cfg_q.caps_on};
      REG_CAPS_OFF:    prdata = {28'd0, cfg_q.caps_off};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

// File: rtl/bwn_div.sv
module bwn_div import bwn_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [7:0] dividend_i,
  input  logic [6:0] divisor_i,
  output logic       busy_o,
  output logic       done_o,
  output logic [7:0] rem_o
);

  logic       busy_q, done_q;
  logic [2:0] cnt_q;
  logic [7:0] rem_q, dvd_q;
  logic [7:0] trial;

  // restoring remainder, one dividend bit a cycle
  assign trial = {rem_q[6:0], dvd_q[7]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 3'd7;
      end else if (busy_q) begin
        if (cnt_q == 3'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= (trial >= {1'b0, divisor_i}) ? trial - {1'b0, divisor_i} : trial;
      dvd_q <= {dvd_q[6:0], 1'b0};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// File: rtl/bwn_ctrl.sv
`include "braille_window_navigator_defines.svh"

module bwn_ctrl import bwn_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  ctrl_sts_t  sts_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIVC_GO,
    ST_DIVC_WAIT,
    ST_DIVX_GO,
    ST_DIVX_WAIT,
    ST_PLACE,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic   ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i && ready_q) begin
            state_q <= ST_EXEC;
            ready_q <= 1'b0;
          end
        end
        ST_EXEC: begin
          state_q <= sts_i.need_place ? ST_DIVC_GO : ST_FINISH;
        end
        ST_DIVC_GO: state_q <= ST_DIVC_WAIT;
        ST_DIVC_WAIT: begin
          if (sts_i.div_done) begin
            state_q <= ST_DIVX_GO;
          end
        end
        ST_DIVX_GO: state_q <= ST_DIVX_WAIT;
        ST_DIVX_WAIT: begin
          if (sts_i.div_done) begin
            state_q <= ST_PLACE;
          end
        end
        ST_PLACE: state_q <= ST_FINISH;
        ST_FINISH: begin
          // hold until the result register is free
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o.take      = ready_q & in_valid_i;
    cmd_o.exec      = (state_q == ST_EXEC);
    cmd_o.div_start = (state_q == ST_DIVC_GO) || (state_q == ST_DIVX_GO);
    cmd_o.div_sel   = (state_q == ST_DIVX_GO) || (state_q == ST_DIVX_WAIT);
    cmd_o.place     = (state_q == ST_PLACE);
    cmd_o.finish    = (state_q == ST_FINISH) && sts_i.out_free;
  end

  assign in_ready_o = ready_q;

  `BWN_ASSERT_IMP(a_start_idle_div, cmd_o.div_start, !sts_i.div_busy,
                  "divider started while busy")
  `BWN_ASSERT_IMP(a_ready_div_idle, in_ready_o, !sts_i.div_busy,
                  "request taken while divider busy")
  `BWN_ASSERT_NXT(a_take_drops_ready, cmd_o.take, !in_ready_o,
                  "ready held after a request was taken")

endmodule

// File: rtl/bwn_dp.sv
`include "braille_window_navigator_defines.svh"

module bwn_dp import bwn_pkg::*; #(
  parameter int MaxWindowCells = DefMaxWindowCells
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  ctrl_cmd_t  cmd_i,
  output ctrl_sts_t  sts_o,
  input  logic       kind_i,
  input  logic [4:0] command_i,
  input  logic [6:0] key_index_i,
  input  logic [7:0] cursor_col_i,
  input  logic [7:0] cursor_row_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] win_col_o,
  output logic [7:0] win_row_o,
  output logic [2:0] cue_o,
  output logic       route_valid_o,
  output logic [7:0] route_col_o,
  output logic [7:0] route_row_o,
  output logic       mark_valid_o,
  output logic [8:0] mark_cell_o,
  output logic       caps_hidden_o,
  output logic [9:0] mode_flags_o
);

  // request held for the whole item
  logic       kind_q;
  logic [4:0] command_q;
  logic [6:0] key_q;
  logic [7:0] cx_q, cy_q;

  logic [7:0] win_col_q, win_row_q, last_col_q, last_row_q, now_col_q, now_row_q;
  logic [9:0] flags_q;
  logic       cph_q, kph_q;
  logic [3:0] cticks_q, kticks_q;
  cue_e       cue_q;
  logic       rt_v_q;
  logic [7:0] rt_c_q, rt_r_q;
  logic [7:0] remc_q, remx_q;

  logic       out_valid_q, o_rt_v_q, o_mark_v_q, o_caps_q;
  logic [7:0] o_col_q, o_row_q, o_rt_c_q, o_rt_r_q;
  logic [2:0] o_cue_q;
  logic [8:0] o_cell_q;
  logic [9:0] o_flags_q;

  logic [7:0] sc, sr, mc, mr;
  logic [6:0] wc;
  logic [2:0] wr;

  assign sc = cfg_i.screen_cols;
  assign sr = cfg_i.screen_rows;
  assign wc = cfg_i.window_cols;
  assign wr = cfg_i.window_rows;
  assign mc = (sc > {1'b0, wc}) ? sc - {1'b0, wc} : 8'd0;
  assign mr = (sr > {5'd0, wr}) ? sr - {5'd0, wr} : 8'd0;

  // ---- divider for the paged placement remainders ----
  logic       div_busy, div_done;
  logic [7:0] div_rem;

  bwn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (cmd_i.div_sel ? now_col_q : sc),
    .divisor_i  (wc),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // ---- command and tick execution ----
  logic [7:0] col_x, row_x;
  cue_e       cue_x;
  logic       rt_v_x;
  logic [7:0] rt_c_x, rt_r_x;
  logic [9:0] flags_x, tog;
  logic       cph_x, kph_x;
  logic [3:0] cticks_x, kticks_x;
  logic [4:0] tog_idx;
  logic       moved, need_place;
  logic [8:0] route_at;
  logic [6:0] half_wc;

  assign moved = (cx_q != last_col_q) || (cy_q != last_row_q);
  assign tog_idx = command_q - CMD_TOG_VISIBLE;
  assign route_at = {1'b0, win_col_q} + {2'b00, key_q};
  assign half_wc = 7'(wc / HALF_DIV);

  always_comb begin
    col_x    = win_col_q;
    row_x    = win_row_q;
    cue_x    = CUE_NONE;
    rt_v_x   = 1'b0;
    rt_c_x   = 8'd0;
    rt_r_x   = 8'd0;
    flags_x  = flags_q;
    cph_x    = cph_q;
    kph_x    = kph_q;
    cticks_x = cticks_q;
    kticks_x = kticks_q;
    tog      = '0;
    if (!kind_q) begin
      case (command_q)
        CMD_TOP: row_x = 8'd0;
        CMD_ORIGIN: begin
          row_x = 8'd0;
          col_x = 8'd0;
        end
        CMD_BOTTOM: row_x = mr;
        CMD_BOTTOM_LEFT: begin
          row_x = mr;
          col_x = 8'd0;
        end
        CMD_WIN_UP: begin
          if (win_row_q == 8'd0) cue_x = CUE_BOUNCE;
          row_x = clamp_pos(sx8(win_row_q) - sw_t'(VERT_STEP), mr);
        end
        CMD_WIN_DOWN: begin
          if (win_row_q == mr) cue_x = CUE_BOUNCE;
          row_x = clamp_pos(sx8(win_row_q) + sw_t'(VERT_STEP), mr);
        end
        CMD_LINE_UP: begin
          if (win_row_q == 8'd0) cue_x = CUE_BOUNCE;
          row_x = clamp_pos(sx8(win_row_q) - sw_t'(1), mr);
        end
        CMD_LINE_DOWN: begin
          if (win_row_q == mr) cue_x = CUE_BOUNCE;
          row_x = clamp_pos(sx8(win_row_q) + sw_t'(1), mr);
        end
        CMD_GO_CURSOR: ;
        CMD_LINE_BEGIN: col_x = 8'd0;
        CMD_LINE_END: col_x = mc;
        CMD_CHAR_LEFT: begin
          if (win_col_q == 8'd0) cue_x = CUE_BOUNCE;
          col_x = clamp_pos(sx8(win_col_q) - sw_t'(1), mc);
        end
        CMD_CHAR_RIGHT: begin
          if (win_col_q == mc) cue_x = CUE_BOUNCE;
          col_x = clamp_pos(sx8(win_col_q) + sw_t'(1), mc);
        end
        CMD_HALF_LEFT: begin
          if (win_col_q == 8'd0) cue_x = CUE_BOUNCE;
          col_x = clamp_pos(sx8(win_col_q) - sx7(half_wc), mc);
        end
        CMD_HALF_RIGHT: begin
          if (win_col_q == mc) cue_x = CUE_BOUNCE;
          col_x = clamp_pos(sx8(win_col_q) + sx7(half_wc), mc);
        end
        CMD_FULL_LEFT: begin
          if (win_col_q == 8'd0 && win_row_q != 8'd0) begin
            col_x = mc;
            row_x = win_row_q - 8'd1;
            cue_x = CUE_WRAP_UP;
          end else if (win_col_q == 8'd0) begin
            cue_x = CUE_BOUNCE;
          end else begin
            col_x = clamp_pos(sx8(win_col_q) - sx7(wc), mc);
          end
        end
        CMD_FULL_RIGHT: begin
          if (win_col_q == mc && win_row_q < mr) begin
            col_x = 8'd0;
            row_x = win_row_q + 8'd1;
            cue_x = CUE_WRAP_DOWN;
          end else if (win_col_q == mc && win_row_q == mr) begin
            cue_x = CUE_BOUNCE;
          end else begin
            col_x = clamp_pos(sx8(win_col_q) + sx7(wc), mc);
          end
        end
        CMD_ROUTE: begin
          if (key_q < wc && route_at < {1'b0, sc}) begin
            rt_v_x = 1'b1;
            rt_c_x = route_at[7:0];
            rt_r_x = win_row_q;
          end
        end
        default: begin
          if (command_q inside {[CMD_TOG_VISIBLE:CMD_TOG_INFO]}) begin
            tog     = 10'd1 << tog_idx[3:0];
            flags_x = flags_q ^ tog;
            cue_x   = (|(flags_x & tog)) ? CUE_ON : CUE_OFF;
            case (command_q)
              CMD_TOG_BLINK: begin
                cph_x = 1'b1;
                if (flags_x[FlagBlink]) begin
                  cticks_x = cfg_i.cur_on;
                  kph_x    = 1'b0;
                  kticks_x = cfg_i.caps_off;
                end
              end
              CMD_TOG_CAPBLINK: begin
                kph_x = 1'b1;
                if (flags_x[FlagCapBlink]) begin
                  kticks_x = cfg_i.caps_on;
                  cph_x    = 1'b0;
                  cticks_x = cfg_i.cur_off;
                end
              end
              CMD_TOG_TRACK: cue_x = flags_x[FlagTrack] ? CUE_LINK : CUE_UNLINK;
              CMD_TOG_SOUND: cue_x = CUE_ON;
              CMD_TOG_ATTRIB, CMD_TOG_INFO: cue_x = CUE_NONE;
              default: ;
            endcase
          end
        end
      endcase
    end else begin
      // restart the cursor blink when the cursor moves, if blink and tracking are on
      if (flags_q[FlagBlink] && flags_q[FlagTrack]) begin
        if (cx_q != last_col_q) begin
          cph_x    = 1'b1;
          cticks_x = cfg_i.cur_on;
        end
        if (cy_q != last_row_q) begin
          cph_x    = 1'b0;
          cticks_x = cfg_i.cur_off;
        end
      end
    end
  end

  always_comb begin
    if (kind_q) begin
      need_place = flags_q[FlagTrack] && moved;
    end else begin
      need_place = (command_q == CMD_GO_CURSOR) ||
                   ((command_q == CMD_TOG_TRACK) && !flags_q[FlagTrack]);
    end
  end

  // ---- window placement around now_col_q / now_row_q ----
  logic [8:0] end_c, end_r;
  logic       outx, outy;
  logic [2:0] wrm1;
  logic [6:0] off;
  sw_t        rowsel, colv, rowv;

  assign end_c = {1'b0, win_col_q} + {2'b00, wc};
  assign end_r = {1'b0, win_row_q} + {6'd0, wr};
  assign wrm1  = wr - 3'd1;
  assign off   = 7'(wc / EDGE_DIV);

  always_comb begin
    outx   = (now_col_q < win_col_q) || ({1'b0, now_col_q} >= end_c);
    outy   = (now_row_q < win_row_q) || ({1'b0, now_row_q} >= end_r);
    rowsel = (now_row_q < {5'd0, wrm1}) ? sw_t'(0) : sx8(now_row_q) - sx7({4'd0, wrm1});
    colv   = sx8(win_col_q);
    rowv   = sx8(win_row_q);
    if (flags_q[FlagSlide]) begin
      if (outx || outy) begin
        rowv = rowsel;
        if (now_col_q < {1'b0, wc}) begin
          colv = sw_t'(0);
        end else if (sx8(now_col_q) >= sx8(sc) - sx7(off)) begin
          colv = sx8(sc) - sx7(wc);
        end else begin
          colv = sx8(now_col_q) - (sx7(wc) - sx7(off));
        end
      end
    end else begin
      if (outx) begin
        colv = (sx8(now_col_q) >= sx8(sc) - sx8(remc_q)) ? sx8(sc) - sx7(wc)
                                                         : sx8(now_col_q) - sx8(remx_q);
      end
      if (outy) begin
        rowv = rowsel;
      end
    end
  end

  // ---- cursor mark, caps phase and blink counters on a tick ----
  logic        inx, iny;
  logic [2:0]  dy;
  logic [6:0]  dx;
  logic [9:0]  mark_idx;
  logic        mark_v, caps_h;
  logic [3:0]  ct_dec, kt_dec;
  logic        cph_f, kph_f;
  logic [3:0]  cticks_f, kticks_f;

  always_comb begin
    inx      = (now_col_q >= win_col_q) && ({1'b0, now_col_q} < end_c);
    iny      = (now_row_q >= win_row_q) && ({1'b0, now_row_q} < end_r);
    dy       = 3'(now_row_q - win_row_q);
    dx       = 7'(now_col_q - win_col_q);
    mark_idx = ({7'd0, dy} * {3'd0, wc}) + {3'd0, dx};
    mark_v   = !flags_q[FlagInfo] && flags_q[FlagVisible] &&
               (!flags_q[FlagBlink] || cph_q) && inx && iny &&
               (int'(mark_idx) < MaxWindowCells);
    caps_h   = !flags_q[FlagInfo] && flags_q[FlagCapBlink] && !kph_q;

    ct_dec   = cticks_q - 4'd1;
    kt_dec   = kticks_q - 4'd1;
    cph_f    = cph_q;
    kph_f    = kph_q;
    cticks_f = cticks_q;
    kticks_f = kticks_q;
    if (flags_q[FlagBlink]) begin
      cticks_f = ct_dec;
      if (ct_dec == 4'd0) begin
        cph_f    = !cph_q;
        cticks_f = cph_f ? cfg_i.cur_on : cfg_i.cur_off;
      end
    end
    if (flags_q[FlagCapBlink]) begin
      kticks_f = kt_dec;
      if (kt_dec == 4'd0) begin
        kph_f    = !kph_q;
        kticks_f = kph_f ? cfg_i.caps_on : cfg_i.caps_off;
      end
    end
  end

  // ---- state ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_col_q  <= '0;
      win_row_q  <= '0;
      last_col_q <= '0;
      last_row_q <= '0;
      now_col_q  <= '0;
      now_row_q  <= '0;
      flags_q    <= FlagsInit;
      cph_q      <= 1'b1;
      kph_q      <= 1'b1;
      cticks_q   <= RstCurOn;
      kticks_q   <= RstCapsOn;
    end else begin
      if (cmd_i.exec) begin
        win_col_q <= col_x;
        win_row_q <= row_x;
        flags_q   <= flags_x;
        cph_q     <= cph_x;
        kph_q     <= kph_x;
        cticks_q  <= cticks_x;
        kticks_q  <= kticks_x;
        if (kind_q) begin
          now_col_q <= cx_q;
          now_row_q <= cy_q;
          if (need_place) begin
            last_col_q <= cx_q;
            last_row_q <= cy_q;
          end
        end
      end else if (cmd_i.place) begin
        win_col_q <= clamp_pos(colv, mc);
        win_row_q <= clamp_pos(rowv, mr);
      end else if (cmd_i.finish && kind_q) begin
        cph_q    <= cph_f;
        kph_q    <= kph_f;
        cticks_q <= cticks_f;
        kticks_q <= kticks_f;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      kind_q    <= kind_i;
      command_q <= command_i;
      key_q     <= key_index_i;
      cx_q      <= cursor_col_i;
      cy_q      <= cursor_row_i;
    end
    if (cmd_i.exec) begin
      cue_q  <= kind_q ? CUE_NONE : cue_x;
      rt_v_q <= kind_q ? 1'b0 : rt_v_x;
      rt_c_q <= kind_q ? 8'd0 : rt_c_x;
      rt_r_q <= kind_q ? 8'd0 : rt_r_x;
    end
    if (div_done) begin
      if (cmd_i.div_sel) begin
        remx_q <= div_rem;
      end else begin
        remc_q <= div_rem;
      end
    end
  end

  // ---- result register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      o_col_q    <= win_col_q;
      o_row_q    <= win_row_q;
      o_cue_q    <= cue_q;
      o_rt_v_q   <= rt_v_q;
      o_rt_c_q   <= rt_c_q;
      o_rt_r_q   <= rt_r_q;
      o_mark_v_q <= kind_q && mark_v;
      o_cell_q   <= (kind_q && mark_v) ? mark_idx[8:0] : 9'd0;
      o_caps_q   <= kind_q && caps_h;
      o_flags_q  <= flags_q;
    end
  end

  assign sts_o.need_place = need_place;
  assign sts_o.div_busy   = div_busy;
  assign sts_o.div_done   = div_done;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign win_col_o     = o_col_q;
  assign win_row_o     = o_row_q;
  assign cue_o         = o_cue_q;
  assign route_valid_o = o_rt_v_q;
  assign route_col_o   = o_rt_c_q;
  assign route_row_o   = o_rt_r_q;
  assign mark_valid_o  = o_mark_v_q;
  assign mark_cell_o   = o_cell_q;
  assign caps_hidden_o = o_caps_q;
  assign mode_flags_o  = o_flags_q;

  `BWN_ASSERT_NXT(a_finish_loads, cmd_i.finish, out_valid_o,
                  "finished item left no result")
  `BWN_ASSERT_IMP(a_route_alone, out_valid_o && route_valid_o,
                  (cue_o == CUE_NONE) && !mark_valid_o, "route result mixed with other output")
  `BWN_ASSERT_IMP(a_info_no_mark, out_valid_o && mark_valid_o, !mode_flags_o[FlagInfo],
                  "cursor mark drawn in info mode")

endmodule

// File: rtl/braille_window_navigator.sv
// Cell-display window navigator. Command requests move the window, toggle mode flags
// or turn a routing key into a screen target; tick requests carry the screen cursor,
// run the blink phases, follow the cursor when tracking and report the cursor mark.
// One request is in flight at a time and each gives one result, held in an output
// register so the next request can be taken while it waits. Each request runs an execute
// step and a finish step; when the window must be placed around the cursor (go to
// cursor, tracking switched on, or a moved cursor while tracking) two 8-step remainder
// passes of the shared bit-serial divider and a placement step run between the two.
// A result not yet taken holds the next request back at its last cycle.
// Registers sit at byte address 4*index on the APB-style port and reset to
// 80 x 25 screen, 40 x 1 window, blink ticks 3/3 (cursor) and 4/2 (capitals).
module braille_window_navigator import bwn_pkg::*; #(
  parameter int MaxWindowCells = DefMaxWindowCells
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [4:0]        command_i,
  input  logic [6:0]        key_index_i,
  input  logic [7:0]        cursor_col_i,
  input  logic [7:0]        cursor_row_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        win_col_o,
  output logic [7:0]        win_row_o,
  output logic [2:0]        cue_o,
  output logic              route_valid_o,
  output logic [7:0]        route_col_o,
  output logic [7:0]        route_row_o,
  output logic              mark_valid_o,
  output logic [8:0]        mark_cell_o,
  output logic              caps_hidden_o,
  output logic [9:0]        mode_flags_o
);

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  bwn_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bwn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bwn_dp #(
    .MaxWindowCells (MaxWindowCells)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .kind_i        (kind_i),
    .command_i     (command_i),
    .key_index_i   (key_index_i),
    .cursor_col_i  (cursor_col_i),
    .cursor_row_i  (cursor_row_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .win_col_o     (win_col_o),
    .win_row_o     (win_row_o),
    .cue_o         (cue_o),
    .route_valid_o (route_valid_o),
    .route_col_o   (route_col_o),
    .route_row_o   (route_row_o),
    .mark_valid_o  (mark_valid_o),
    .mark_cell_o   (mark_cell_o),
    .caps_hidden_o (caps_hidden_o),
    .mode_flags_o  (mode_flags_o)
  );

endmodule
